### hdl/dbc_pkg.sv
// ----------------------------------------------------------------------------
// dbc_pkg: shared types and constants for the debounced button counter
// Holds the timer width, register indexes, phase codes and result type.
// ----------------------------------------------------------------------------
package dbc_pkg;

  // Width of the debounce down-timer.
  localparam int TIMER_WIDTH = 16;
  localparam int CFG_W       = 16;
  localparam int CFG_IDX_W   = 2;

  typedef logic [TIMER_WIDTH-1:0] timer_t;
  typedef logic [CFG_W-1:0]       cfg_word_t;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_PRESS_WAIT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RELEASE_WAIT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_POLL         = 2'd2;

  // Reset values of the configuration registers.
  localparam cfg_word_t PRESS_WAIT_RST   = 16'd100;
  localparam cfg_word_t RELEASE_WAIT_RST = 16'd100;
  localparam cfg_word_t POLL_RST         = 16'd10;

  // Pending masks that move the count.
  localparam logic [3:0] MASK_UP   = 4'h4;
  localparam logic [3:0] MASK_DOWN = 4'h8;

  // Both buttons released (pins pulled up).
  localparam logic [1:0] LEVELS_RELEASED = 2'b11;

  // Phase codes as they appear on the result channel.
  localparam logic [1:0] PH_IDLE    = 2'd0;
  localparam logic [1:0] PH_PRESS   = 2'd1;
  localparam logic [1:0] PH_POLL    = 2'd2;
  localparam logic [1:0] PH_RELEASE = 2'd3;

  // Item kinds.
  localparam logic MODE_EDGE = 1'b0;
  localparam logic MODE_TICK = 1'b1;

  // One result item.
  typedef struct packed {
    logic [3:0] count_value;
    logic [1:0] phase;
    logic       press_taken;
  } dbc_result_t;

  // A loaded wait is truncated or extended to the timer width.
  function automatic timer_t load_ticks(input cfg_word_t ticks);
    return TIMER_WIDTH'(ticks);
  endfunction

endpackage

### hdl/dbc_core.sv
// ----------------------------------------------------------------------------
// dbc_core: count, phase and debounce timer
// Holds the configuration and the debounce state, and computes the result
// of the presented item from the current state.
// ----------------------------------------------------------------------------
module dbc_core import dbc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  cfg_word_t            cfg_wdata,
  input  logic                 step_en,
  input  logic                 mode,
  input  logic [3:0]           pend_mask,
  input  logic [1:0]           button_levels,
  output dbc_result_t          res
);

  typedef enum logic [3:0] {
    ST_IDLE    = 4'b0001,
    ST_PRESS   = 4'b0010,
    ST_POLL    = 4'b0100,
    ST_RELEASE = 4'b1000
  } state_t;

  cfg_word_t press_wait_r;
  cfg_word_t release_wait_r;
  cfg_word_t poll_r;

  state_t     state_r, state_nxt;
  logic [3:0] count_r, count_nxt;
  timer_t     timer_r, timer_nxt;
  logic       taken;
  logic       fire;

  // Configuration writes; an index past the list is ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      press_wait_r   <= PRESS_WAIT_RST;
      release_wait_r <= RELEASE_WAIT_RST;
      poll_r         <= POLL_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_PRESS_WAIT:   press_wait_r   <= cfg_wdata;
        REG_RELEASE_WAIT: release_wait_r <= cfg_wdata;
        REG_POLL:         poll_r         <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // The running wait ends on a tick that finds one or zero left.
  assign fire = (timer_r <= TIMER_WIDTH'(1));

  // Next state for the presented item.
  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    timer_nxt = timer_r;
    taken     = 1'b0;
    if (mode == MODE_EDGE) begin
      if (state_r == ST_IDLE) begin
        if (pend_mask == MASK_UP) begin
          count_nxt = count_r + 4'd1;
        end else if (pend_mask == MASK_DOWN) begin
          count_nxt = count_r - 4'd1;
        end
        timer_nxt = load_ticks(press_wait_r);
        state_nxt = ST_PRESS;
        taken     = 1'b1;
      end
    end else begin
      case (state_r)
        ST_PRESS: begin
          if (fire) begin
            timer_nxt = load_ticks(poll_r);
            state_nxt = ST_POLL;
          end else begin
            timer_nxt = timer_r - TIMER_WIDTH'(1);
          end
        end
        ST_POLL: begin
          if (fire) begin
            if (button_levels != LEVELS_RELEASED) begin
              timer_nxt = load_ticks(poll_r);
            end else begin
              timer_nxt = load_ticks(release_wait_r);
              state_nxt = ST_RELEASE;
            end
          end else begin
            timer_nxt = timer_r - TIMER_WIDTH'(1);
          end
        end
        ST_RELEASE: begin
          if (fire) begin
            timer_nxt = '0;
            state_nxt = ST_IDLE;
          end else begin
            timer_nxt = timer_r - TIMER_WIDTH'(1);
          end
        end
        default: ;
      endcase
    end
  end

  // State update on each accepted item.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= '0;
      timer_r <= '0;
    end else if (step_en) begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      timer_r <= timer_nxt;
    end
  end

  // Result fields, taken after the update.
  always_comb begin
    res.count_value = count_nxt;
    res.press_taken = taken;
    case (state_nxt)
      ST_IDLE:    res.phase = PH_IDLE;
      ST_PRESS:   res.phase = PH_PRESS;
      ST_POLL:    res.phase = PH_POLL;
      ST_RELEASE: res.phase = PH_RELEASE;
      default:    res.phase = PH_IDLE;
    endcase
  end

endmodule

### hdl/debounced_up_down_button_counter.sv
// ----------------------------------------------------------------------------
// debounced_up_down_button_counter: up/down count with timer debounce
// Stream wrapper around the debounce core with a two-entry result buffer.
// ----------------------------------------------------------------------------
// Each input item is a button edge event or a one-unit time tick, and each
// gives exactly one result item with the count, the phase and a flag for an
// accepted press. An item is taken in every cycle while the result buffer has
// room; its result is registered into the buffer and sent on the output in
// order. The buffer holds two results, so input keeps flowing after the output
// stalls until the skid entry is full. Configuration writes take effect at once
// and are meant for idle periods.
module debounced_up_down_button_counter import dbc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  // Configuration write port.
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  cfg_word_t            cfg_wdata,
  // Input items.
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [7:0]           in_tdata,   // [3:0] pend_mask, [5:4] button_levels
  input  logic                 in_tuser,   // [0] mode
  // Result items.
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [7:0]           out_tdata   // [3:0] count_value, [5:4] phase,
                                           // [6] press_taken
);

  dbc_result_t res;
  dbc_result_t main_r, main_nxt;
  dbc_result_t skid_r, skid_nxt;
  logic        main_v_r, main_v_nxt;
  logic        skid_v_r, skid_v_nxt;
  logic        push, pop;

  assign in_tready = !skid_v_r;
  assign push      = in_tvalid && in_tready;
  assign pop       = main_v_r && out_tready;

  dbc_core u_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .step_en       (push),
    .mode          (in_tuser),
    .pend_mask     (in_tdata[3:0]),
    .button_levels (in_tdata[5:4]),
    .res           (res)
  );

  // Result buffer: main entry drives the port, skid entry catches overflow.
  always_comb begin
    main_nxt   = main_r;
    skid_nxt   = skid_r;
    main_v_nxt = main_v_r;
    skid_v_nxt = skid_v_r;
    if (pop) begin
      main_nxt   = skid_r;
      main_v_nxt = skid_v_r;
      skid_v_nxt = 1'b0;
    end
    if (push) begin
      if (!main_v_nxt) begin
        main_nxt   = res;
        main_v_nxt = 1'b1;
      end else begin
        skid_nxt   = res;
        skid_v_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      main_v_r <= main_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

  assign out_tvalid = main_v_r;
  assign out_tdata  = {1'b0, main_r.press_taken, main_r.phase, main_r.count_value};

  // The skid entry is only ever filled behind a valid main entry.
  a_skid_behind_main: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> main_v_r)
    else $error("skid entry valid without main entry");

  // An accepted press always leaves the block in the press wait.
  a_press_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (push && res.press_taken) |-> (res.phase == PH_PRESS))
    else $error("press taken without entering press wait");

  // A press is only taken for an edge item.
  a_press_on_edge: assert property (@(posedge clk) disable iff (!rst_n)
    (push && res.press_taken) |-> (in_tuser == MODE_EDGE))
    else $error("press taken on a tick item");

  // A held result stays put while the output stalls.
  a_main_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (main_v_r && !out_tready) |=> (main_r == $past(main_r)))
    else $error("stalled result changed");

endmodule

### sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the debounced up/down button counter
// Drives edge and tick items over the input stream and checks every result
// item against a cycle-free predictor of the count, phase and timer, with
// random idling on both sides and configuration changes between phases.
// ----------------------------------------------------------------------------
module tb_top import dbc_pkg::*; ();

  // Index with no register behind it; writes to it must change nothing.
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam int unsigned CYCLE_LIMIT     = 1_000_000;
  localparam int          HOLD_OFF_CYCLES = 64;

  // One input item as the bench sees it.
  typedef struct packed {
    logic       mode;
    logic [3:0] mask;
    logic [1:0] levels;
  } button_event_t;

  // Predictor of the debounce sequence plus the queue of expected results.
  class debounce_scoreboard;
    logic [3:0]    count_q;
    logic [1:0]    phase_q;
    timer_t        timer_q;
    cfg_word_t     press_wait;
    cfg_word_t     release_wait;
    cfg_word_t     poll_wait;
    dbc_result_t   expected_status[$];
    int            errors;

    function new();
      count_q      = '0;
      phase_q      = PH_IDLE;
      timer_q      = '0;
      press_wait   = PRESS_WAIT_RST;
      release_wait = RELEASE_WAIT_RST;
      poll_wait    = POLL_RST;
      errors       = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, cfg_word_t val);
      case (idx)
        REG_PRESS_WAIT:   press_wait   = val;
        REG_RELEASE_WAIT: release_wait = val;
        REG_POLL:         poll_wait    = val;
        default: ;
      endcase
    endfunction

    // A running wait ends on the tick that finds one or less left.
    function bit debounce_wait_over();
      if (timer_q <= timer_t'(1)) begin
        timer_q = '0;
        return 1'b1;
      end
      timer_q = timer_q - timer_t'(1);
      return 1'b0;
    endfunction

    function int pending();
      return expected_status.size();
    endfunction

    // Advance the predicted state by one accepted item and queue its result.
    function void note_event(logic mode, logic [3:0] mask, logic [1:0] levels);
      dbc_result_t st;
      logic        taken;
      taken = 1'b0;
      if (mode == MODE_EDGE) begin
        if (phase_q == PH_IDLE) begin
          if (mask == MASK_UP)        count_q = count_q + 4'd1;
          else if (mask == MASK_DOWN) count_q = count_q - 4'd1;
          timer_q = timer_t'(press_wait);
          phase_q = PH_PRESS;
          taken   = 1'b1;
        end
      end else begin
        case (phase_q)
          PH_PRESS: begin
            if (debounce_wait_over()) begin
              timer_q = timer_t'(poll_wait);
              phase_q = PH_POLL;
            end
          end
          PH_POLL: begin
            if (debounce_wait_over()) begin
              if (levels != LEVELS_RELEASED) begin
                timer_q = timer_t'(poll_wait);
              end else begin
                timer_q = timer_t'(release_wait);
                phase_q = PH_RELEASE;
              end
            end
          end
          PH_RELEASE: begin
            if (debounce_wait_over()) phase_q = PH_IDLE;
          end
          default: ;
        endcase
      end
      st.count_value = count_q;
      st.phase       = phase_q;
      st.press_taken = taken;
      expected_status.push_back(st);
    endfunction

    task report(string msg);
      $display("[%0t] MISMATCH: %s", $time, msg);
      errors++;
    endtask

    // Compare one accepted result item against the oldest expectation.
    task check_status(logic [7:0] data);
      dbc_result_t got;
      dbc_result_t want;
      got.count_value = data[3:0];
      got.phase       = data[5:4];
      got.press_taken = data[6];
      if (expected_status.size() == 0) begin
        report($sformatf("result item 0x%02h arrived with nothing expected", data));
        return;
      end
      want = expected_status.pop_front();
      if (got.count_value != want.count_value)
        report($sformatf("count_value got %0d want %0d", got.count_value, want.count_value));
      if (got.phase != want.phase)
        report($sformatf("phase got %0d want %0d", got.phase, want.phase));
      if (got.press_taken != want.press_taken)
        report($sformatf("press_taken got %0b want %0b", got.press_taken, want.press_taken));
    endtask
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_wr_en;
  logic [CFG_IDX_W-1:0] cfg_index;
  cfg_word_t            cfg_wdata;
  logic                 in_tvalid;
  logic                 in_tready;
  logic [7:0]           in_tdata;   // [3:0] pend_mask, [5:4] button_levels
  logic                 in_tuser;   // [0] mode
  logic                 out_tvalid;
  logic                 out_tready;
  logic [7:0]           out_tdata;  // [3:0] count_value, [5:4] phase, [6] press_taken

  debounce_scoreboard sb;
  logic               in_taken;
  logic               quiet;
  logic               hold_off_req;
  int unsigned        cycle_count;

  debounced_up_down_button_counter DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog on the whole run.
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Both handshakes are sampled at the rising edge; the sender reads in_taken
  // at the following falling edge.
  initial in_taken = 1'b0;
  always @(posedge clk) begin
    in_taken = rst_n && in_tvalid && in_tready;
    if (rst_n) begin
      if (in_tvalid && in_tready) sb.note_event(in_tuser, in_tdata[3:0], in_tdata[5:4]);
      if (out_tvalid && out_tready) sb.check_status(out_tdata);
    end
  end

  // Result side: random stall bursts, plus one long hold-off when asked.
  initial begin
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      if (hold_off_req) begin
        out_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
        hold_off_req = 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(negedge clk);
      end else begin
        out_tready <= 1'b1;
        @(negedge clk);
      end
    end
  end

  // Offer one item and return at the falling edge after it was accepted.
  task automatic send_item(input logic mode, input logic [3:0] mask, input logic [1:0] levels);
    in_tvalid <= 1'b1;
    in_tuser  <= mode;
    in_tdata  <= {2'b00, levels, mask};
    do @(negedge clk); while (!in_taken);
  endtask

  // Send an item, then now and then leave a gap on the input.
  task automatic offer(input logic mode, input logic [3:0] mask, input logic [1:0] levels);
    send_item(mode, mask, levels);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk);
    end
  endtask

  task automatic wait_for_results();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
  endtask

  // Send ticks with both buttons released until the block is back in idle.
  task automatic tick_to_idle();
    while (sb.phase_q != PH_IDLE) offer(MODE_TICK, 4'h0, LEVELS_RELEASED);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input cfg_word_t val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    sb.write_reg(idx, val);
    @(negedge clk);
  endtask

  // New register settings, written once the block has nothing in flight.
  task automatic apply_settings(input cfg_word_t press, input cfg_word_t rel,
                                input cfg_word_t poll);
    wait_for_results();
    repeat (4) @(negedge clk);
    cfg_write(REG_PRESS_WAIT, press);
    cfg_write(REG_RELEASE_WAIT, rel);
    cfg_write(REG_POLL, poll);
    cfg_write(REG_UNUSED, cfg_word_t'($urandom_range(0, 65535)));
    cfg_wr_en <= 1'b0;
  endtask

  // Mostly ticks and up/down presses, with released pins at least half the time so
  // that press sequences run to the end.
  function automatic button_event_t random_event();
    button_event_t ev;
    int            pick;
    ev.mode = ($urandom_range(0, 3) != 0) ? MODE_TICK : MODE_EDGE;
    pick = $urandom_range(0, 9);
    if (pick < 4)      ev.mask = MASK_UP;
    else if (pick < 8) ev.mask = MASK_DOWN;
    else               ev.mask = 4'($urandom_range(0, 15));
    ev.levels = ($urandom_range(0, 1) != 0) ? LEVELS_RELEASED : 2'($urandom_range(0, 3));
    return ev;
  endfunction

  task automatic run_random_phase(input int n_items, input int hold_at, input int pause_at);
    button_event_t ev;
    for (int i = 0; i < n_items; i++) begin
      if (i == hold_at) hold_off_req = 1'b1;
      if (i == pause_at) wait_for_results();
      ev = random_event();
      offer(ev.mode, ev.mask, ev.levels);
    end
  endtask

  initial begin
    sb           = new();
    rst_n        = 1'b0;
    cfg_wr_en    = 1'b0;
    cfg_index    = '0;
    cfg_wdata    = '0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    in_tuser     = MODE_EDGE;
    out_tready   = 1'b0;
    quiet        = 1'b0;
    hold_off_req = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset settings, with a long output hold-off and a full drain mid-way.
    run_random_phase(300, 100, 200);

    // Directed walk: zero press wait, short poll and release waits.
    apply_settings(16'd0, 16'd1, 16'd2);
    tick_to_idle();
    offer(MODE_TICK, 4'h0, 2'b00);              // tick in idle does nothing
    offer(MODE_EDGE, MASK_DOWN, 2'b11);         // down by one, modulo 16
    offer(MODE_EDGE, MASK_UP, 2'b00);           // edge outside idle is ignored
    offer(MODE_TICK, 4'hF, 2'b00);              // zero wait ends on first tick
    offer(MODE_TICK, 4'h0, 2'b00);
    offer(MODE_TICK, 4'h0, 2'b01);              // poll with a button held
    offer(MODE_TICK, 4'h0, 2'b10);
    offer(MODE_TICK, 4'h0, 2'b10);              // other button held
    offer(MODE_TICK, 4'h0, LEVELS_RELEASED);
    offer(MODE_TICK, 4'h0, LEVELS_RELEASED);    // both released
    offer(MODE_EDGE, MASK_UP, LEVELS_RELEASED); // ignored in release wait
    offer(MODE_TICK, 4'h0, LEVELS_RELEASED);    // back to idle
    offer(MODE_EDGE, MASK_UP, 2'b00);           // up by one, modulo 16
    offer(MODE_TICK, 4'h0, 2'b00);
    offer(MODE_TICK, 4'h0, LEVELS_RELEASED);
    offer(MODE_TICK, 4'h0, LEVELS_RELEASED);
    offer(MODE_TICK, 4'h0, LEVELS_RELEASED);
    offer(MODE_EDGE, 4'h0, LEVELS_RELEASED);    // other mask: taken, no count
    offer(MODE_TICK, 4'h0, LEVELS_RELEASED);
    offer(MODE_TICK, 4'h0, LEVELS_RELEASED);
    offer(MODE_TICK, 4'h0, LEVELS_RELEASED);
    offer(MODE_TICK, 4'h0, LEVELS_RELEASED);
    offer(MODE_EDGE, 4'hF, LEVELS_RELEASED);    // all mask bits set

    apply_settings(16'd1, 16'd1, 16'd1);
    run_random_phase(300, -1, -1);
    apply_settings(16'd3, 16'd5, 16'd2);
    run_random_phase(300, 150, -1);
    apply_settings(cfg_word_t'($urandom_range(1, 8)), cfg_word_t'($urandom_range(1, 8)),
                   cfg_word_t'($urandom_range(1, 8)));
    run_random_phase(300, -1, 120);
    apply_settings(16'd0, 16'd0, 16'd0);
    run_random_phase(300, -1, -1);

    // Closing stretch at full rate on both sides.
    quiet = 1'b1;
    apply_settings(cfg_word_t'($urandom_range(1, 12)), cfg_word_t'($urandom_range(1, 12)),
                   cfg_word_t'($urandom_range(1, 12)));
    run_random_phase(300, -1, -1);

    // Longest waits: load the widest timer values and count down from the top.
    tick_to_idle();
    apply_settings(16'hFFFF, 16'hFFFF, 16'hFFFF);
    offer(MODE_EDGE, MASK_UP, LEVELS_RELEASED);
    repeat (64) offer(MODE_TICK, 4'h0, 2'b00);

    wait_for_results();
    repeat (4) @(negedge clk);
    if (sb.pending() != 0) sb.report($sformatf("%0d expected results never came", sb.pending()));
    if (sb.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
